// ----- hdl/vtpg_pkg.sv -----
package vtpg_pkg;

   localparam int CELL_W  = 16;
   localparam int CELL_H  = 8;
   localparam int MAX_DIM = 1024;

   localparam int CX_SH = 10 + $clog2(CELL_W);
   localparam int CX_M  = ((1 << CX_SH) + CELL_W - 1) / CELL_W;
   localparam int CY_SH = 10 + $clog2(CELL_H);
   localparam int CY_M  = ((1 << CY_SH) + CELL_H - 1) / CELL_H;

   localparam logic [31:0] HASH_X  = 32'h9E3779B1;
   localparam logic [31:0] HASH_Y  = 32'h85EBCA77;
   localparam logic [31:0] HASH_F  = 32'hC2B2AE3D;
   localparam logic [31:0] HASH_M1 = 32'h7FEB352D;
   localparam logic [31:0] HASH_M2 = 32'h846CA68B;

   localparam logic [15:0] AUTO_POS = 16'hFFFF;

   localparam logic [10:0] RST_HEIGHT = 11'd240;
   localparam logic [7:0]  RST_LOW    = 8'd0;
   localparam logic [7:0]  RST_HIGH   = 8'd255;
   localparam logic [31:0] RST_SEED   = 32'h43525453;

   typedef enum logic [2:0] {
      PAT_HRAMP,
      PAT_VRAMP,
      PAT_CHECKER,
      PAT_NOISE,
      PAT_IMPULSE,
      PAT_CHIRP,
      PAT_MARKERS,
      PAT_FILL
   } pattern_type;

   typedef enum logic [2:0] {
      CSR_PATTERN,
      CSR_HEIGHT,
      CSR_LOW,
      CSR_HIGH,
      CSR_MID,
      CSR_SEED,
      CSR_ICOL,
      CSR_ILINE
   } csr_addr_type;

   typedef struct packed {
      logic [9:0]  px;
      logic [9:0]  ln;
      logic [10:0] wd;
      logic [31:0] fr;
      logic        inb;
      logic        chk;
      logic        noise;
      logic [31:0] f7;
      logic [31:0] f3;
      logic [7:0]  hq;
      logic [7:0]  vq;
      logic [10:0] icol;
      logic [10:0] ilin;
      logic [6:0]  per;
      logic [6:0]  pha;
   } ctx_type;

endpackage

// ----- hdl/vtpg_if.sv -----
interface vtpg_req_if;
   logic        valid;
   logic        ready;
   logic [9:0]  pixel_x;
   logic [9:0]  line;
   logic [10:0] line_width;
   logic [31:0] frame_number;

   modport source (output valid, pixel_x, line, line_width, frame_number, input ready);
   modport sink (input valid, pixel_x, line, line_width, frame_number, output ready);
endinterface

interface vtpg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_index;
   logic       index_valid;

   modport source (output valid, pixel_index, index_valid, input ready);
   modport sink (input valid, pixel_index, index_valid, output ready);
endinterface

interface vtpg_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/vtpg_div.sv -----
module vtpg_div #(
   parameter int NW = 32,
   parameter int DW = 11,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_vld,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [TW-1:0] tag_in,
   output logic          out_vld,
   output logic [NW-1:0] quo,
   output logic [DW-1:0] rem,
   output logic [TW-1:0] tag_out
);

   // One quotient bit per stage, restoring division.
   logic          vld_ff  [NW];
   logic [DW-1:0] rem_ff  [NW];
   logic [NW-1:0] rest_ff [NW];
   logic [NW-1:0] quo_ff  [NW];
   logic [DW-1:0] den_ff  [NW];
   logic [TW-1:0] tag_ff  [NW];

   for (genvar i = 0; i < NW; i++) begin : g_step
      logic          v_i;
      logic [DW-1:0] r_i;
      logic [NW-1:0] s_i;
      logic [NW-1:0] q_i;
      logic [DW-1:0] d_i;
      logic [TW-1:0] t_i;
      logic [DW:0]   cand;
      logic [DW:0]   diff;
      logic          ge;

      if (i == 0) begin : g_first
         assign v_i = in_vld;
         assign r_i = '0;
         assign s_i = num;
         assign q_i = '0;
         assign d_i = den;
         assign t_i = tag_in;
      end else begin : g_next
         assign v_i = vld_ff[i-1];
         assign r_i = rem_ff[i-1];
         assign s_i = rest_ff[i-1];
         assign q_i = quo_ff[i-1];
         assign d_i = den_ff[i-1];
         assign t_i = tag_ff[i-1];
      end

      assign cand = {r_i, s_i[NW-1]};
      assign diff = cand - {1'b0, d_i};
      assign ge   = (cand >= {1'b0, d_i});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= v_i;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= ge ? diff[DW-1:0] : cand[DW-1:0];
            rest_ff[i] <= s_i << 1;
            quo_ff[i]  <= NW'({q_i, ge});
            den_ff[i]  <= d_i;
            tag_ff[i]  <= t_i;
         end
      end
   end

   assign out_vld = vld_ff[NW-1];
   assign quo     = quo_ff[NW-1];
   assign rem     = rem_ff[NW-1];
   assign tag_out = tag_ff[NW-1];

endmodule

// ----- hdl/video_test_pattern_generator.sv -----
// Channel  Direction  Payload
// req_ch   in         pixel_x, line, line_width, frame_number
// rsp_ch   out        pixel_index, index_valid
// csr_ch   in         index, data (always ready)
//
// One request enters every cycle while the response is not stalled.
// The latency is set by three chained bit-serial divider pipelines
// (32, 32 and 11 stages) behind four input and hash stages.
// Reset is synchronous; it clears the valid bits and loads the CSR defaults.
// A stalled response holds the whole pipeline; nothing is dropped.
module video_test_pattern_generator
   import vtpg_pkg::*;
(
   input logic        clock,
   input logic        reset,
   vtpg_req_if.sink   req_ch,
   vtpg_rsp_if.source rsp_ch,
   vtpg_csr_if.sink   csr_ch
);

   localparam int CTX_W = $bits(ctx_type);

   pattern_type pat_ff;
   logic [10:0] fh_ff;
   logic [7:0]  low_ff;
   logic [7:0]  high_ff;
   logic [31:0] seed_ff;
   logic [15:0] icol_ff;
   logic [15:0] iline_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff   <= PAT_MARKERS;
         fh_ff    <= RST_HEIGHT;
         low_ff   <= RST_LOW;
         high_ff  <= RST_HIGH;
         seed_ff  <= RST_SEED;
         icol_ff  <= AUTO_POS;
         iline_ff <= AUTO_POS;
      end else if (csr_ch.valid) begin
         unique case (csr_addr_type'(csr_ch.index))
            CSR_PATTERN: pat_ff   <= pattern_type'(csr_ch.data[2:0]);
            CSR_HEIGHT:  fh_ff    <= csr_ch.data[10:0];
            CSR_LOW:     low_ff   <= csr_ch.data[7:0];
            CSR_HIGH:    high_ff  <= csr_ch.data[7:0];
            CSR_MID:     ;
            CSR_SEED:    seed_ff  <= csr_ch.data;
            CSR_ICOL:    icol_ff  <= csr_ch.data[15:0];
            CSR_ILINE:   iline_ff <= csr_ch.data[15:0];
            default:     ;
         endcase
      end
   end

   logic en;
   logic out_vld_ff;
   logic [7:0] idx_ff;
   logic iv_ff;

   assign en           = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // Input, hash and checker stages.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   ctx_type c1_ff, c2_ff, c3_ff, c4_ff;
   ctx_type c1_in, c2_in, c3_in, c4_in;
   logic [31:0] h0_ff, h1_ff;
   logic [31:0] h0_in, h1_in, h2;
   logic [31:0] pxm, lnm;

   always_comb begin
      c1_in     = '0;
      c1_in.px  = req_ch.pixel_x;
      c1_in.ln  = req_ch.line;
      c1_in.wd  = req_ch.line_width;
      c1_in.fr  = req_ch.frame_number;
      c1_in.inb = ({1'b0, req_ch.line} < fh_ff) && (req_ch.line_width != 11'd0)
                  && (32'(req_ch.line_width) <= 32'(MAX_DIM))
                  && ({1'b0, req_ch.pixel_x} < req_ch.line_width);

      pxm       = 32'(c1_ff.px) * 32'(CX_M);
      lnm       = 32'(c1_ff.ln) * 32'(CY_M);
      h0_in     = seed_ff ^ (32'(c1_ff.px) * HASH_X) ^ (32'(c1_ff.ln) * HASH_Y)
                  ^ (c1_ff.fr * HASH_F);
      c2_in     = c1_ff;
      c2_in.chk = pxm[CX_SH] ^ lnm[CY_SH];
      c2_in.f7  = c1_ff.fr * 32'd7;
      c2_in.f3  = c1_ff.fr * 32'd3;

      h1_in     = (h0_ff ^ (h0_ff >> 16)) * HASH_M1;
      c3_in     = c2_ff;

      h2          = (h1_ff ^ (h1_ff >> 15)) * HASH_M2;
      c4_in       = c3_ff;
      c4_in.noise = h2[31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_ch.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff <= c1_in;
         c2_ff <= c2_in;
         h0_ff <= h0_in;
         c3_ff <= c3_in;
         h1_ff <= h1_in;
         c4_ff <= c4_in;
      end
   end

   // First divider group: ramps, automatic impulse position, chirp period.
   logic [10:0] ymax, ydiv;
   logic [31:0] qh, qv, qc, ql, qp;
   logic [10:0] rh, rv, rc, rl, rp;
   logic [CTX_W-1:0] t5;
   logic g1_vld;
   ctx_type c5;

   assign ymax = fh_ff - 11'd1;
   assign ydiv = (ymax != 11'd0) ? ymax : 11'd1;

   vtpg_div #(.NW(32), .DW(11), .TW(CTX_W)) u_div_h (
      .clock(clock), .reset(reset), .en(en), .in_vld(v4_ff),
      .num(32'(c4_ff.px) * 32'd255), .den(c4_ff.wd - 11'd1), .tag_in(CTX_W'(c4_ff)),
      .out_vld(g1_vld), .quo(qh), .rem(rh), .tag_out(t5));

   vtpg_div #(.NW(32), .DW(11), .TW(1)) u_div_v (
      .clock(clock), .reset(reset), .en(en), .in_vld(v4_ff),
      .num(32'(c4_ff.ln) * 32'd255), .den(ymax), .tag_in(1'b0),
      .out_vld(), .quo(qv), .rem(rv), .tag_out());

   vtpg_div #(.NW(32), .DW(11), .TW(1)) u_div_c (
      .clock(clock), .reset(reset), .en(en), .in_vld(v4_ff),
      .num(c4_ff.f7), .den(c4_ff.wd), .tag_in(1'b0),
      .out_vld(), .quo(qc), .rem(rc), .tag_out());

   vtpg_div #(.NW(32), .DW(11), .TW(1)) u_div_l (
      .clock(clock), .reset(reset), .en(en), .in_vld(v4_ff),
      .num(c4_ff.f3), .den(fh_ff), .tag_in(1'b0),
      .out_vld(), .quo(ql), .rem(rl), .tag_out());

   vtpg_div #(.NW(32), .DW(11), .TW(1)) u_div_p (
      .clock(clock), .reset(reset), .en(en), .in_vld(v4_ff),
      .num(32'(c4_ff.ln) * 32'd62), .den(ydiv), .tag_in(1'b0),
      .out_vld(), .quo(qp), .rem(rp), .tag_out());

   always_comb begin
      c5      = ctx_type'(t5);
      c5.hq   = (c5.wd == 11'd1) ? 8'd0 : qh[7:0];
      c5.vq   = (fh_ff == 11'd1) ? 8'd0 : qv[7:0];
      c5.icol = rc;
      c5.ilin = rl;
      c5.per  = 7'd2 + {1'b0, qp[5:0]};
   end

   // Second group: chirp phase, then the position within the period.
   logic [31:0] q2;
   logic [6:0]  r2;
   logic [CTX_W-1:0] t6, t7;
   logic g2_vld, g3_vld;
   ctx_type c6, c7;
   logic [10:0] q3;
   logic [6:0]  r3;

   vtpg_div #(.NW(32), .DW(7), .TW(CTX_W)) u_div_ph (
      .clock(clock), .reset(reset), .en(en), .in_vld(g1_vld),
      .num(c5.fr), .den(c5.per), .tag_in(CTX_W'(c5)),
      .out_vld(g2_vld), .quo(q2), .rem(r2), .tag_out(t6));

   always_comb begin
      c6     = ctx_type'(t6);
      c6.pha = r2;
   end

   vtpg_div #(.NW(11), .DW(7), .TW(CTX_W)) u_div_ch (
      .clock(clock), .reset(reset), .en(en), .in_vld(g2_vld),
      .num({1'b0, c6.px} + {4'd0, c6.pha}), .den(c6.per), .tag_in(CTX_W'(c6)),
      .out_vld(g3_vld), .quo(q3), .rem(r3), .tag_out(t7));

   assign c7 = ctx_type'(t7);

   // Pattern selection and output register.
   logic [15:0] ix, iy;
   logic [8:0]  rsum;
   logic [7:0]  pix;

   always_comb begin
      ix   = (icol_ff == AUTO_POS) ? {5'd0, c7.icol} : icol_ff;
      iy   = (iline_ff == AUTO_POS) ? {5'd0, c7.ilin} : iline_ff;
      rsum = {1'b0, c7.hq} + {1'b0, c7.vq};
      case (pat_ff)
         PAT_HRAMP:   pix = c7.hq;
         PAT_VRAMP:   pix = c7.vq;
         PAT_CHECKER: pix = c7.chk ? high_ff : low_ff;
         PAT_NOISE:   pix = c7.noise ? high_ff : low_ff;
         PAT_IMPULSE: begin
            pix = ((16'(c7.ln) == iy) && (16'(c7.px) == ix)) ? high_ff : low_ff;
         end
         PAT_CHIRP:   pix = (r3 < (c7.per >> 1)) ? high_ff : low_ff;
         PAT_MARKERS: begin
            if (c7.ln < 10'd8) begin
               if (c7.px[4:0] == 5'd0) begin
                  pix = high_ff;
               end else begin
                  pix = c7.fr[c7.ln[2:0]] ? high_ff : low_ff;
               end
            end else if ((fh_ff > 11'd8) && ({1'b0, c7.ln} >= (fh_ff - 11'd8))) begin
               pix = c7.px[4] ? high_ff : low_ff;
            end else begin
               pix = rsum[8:1];
            end
         end
         default:     pix = low_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= g3_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         idx_ff <= c7.inb ? pix : 8'd0;
         iv_ff  <= c7.inb;
      end
   end

   assign rsp_ch.valid       = out_vld_ff;
   assign rsp_ch.pixel_index = idx_ff;
   assign rsp_ch.index_valid = iv_ff;

   a_oob_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.index_valid |-> rsp_ch.pixel_index == 8'd0)
      else $error("Out of bounds response carries a nonzero index.");

   a_fill_low: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.index_valid && (pat_ff == PAT_FILL)
      |-> rsp_ch.pixel_index == low_ff)
      else $error("Fill pattern did not return the low index.");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready == (!rsp_ch.valid || rsp_ch.ready))
      else $error("Request ready does not follow the output stall.");

endmodule
